// ----- hw/rtl/pld_pkg.sv -----
// Shared types and constants for the PalmDoc LZ77 decompressor.
`timescale 1ns / 1ps
`default_nettype none
package pld_pkg;

  localparam int HIST_DEPTH = 2048;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int DIST_W     = 11;
  localparam int LEN_W      = 4;
  localparam int COUNT_W    = 12;
  localparam logic [COUNT_W-1:0] COUNT_SAT = 12'd2048;

  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);

  localparam logic [7:0]       SPACE_CHAR = 8'h20;
  localparam logic [7:0]       HIGH_FLIP  = 8'h80;
  localparam logic [7:0]       PAIR_BASE  = 8'd128;
  localparam logic [7:0]       SPACE_BASE = 8'd192;
  localparam logic [7:0]       RUN_MAX    = 8'd8;
  localparam logic [LEN_W-1:0] LEN_BIAS   = 4'd3;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TRUNC_LIT  = 2'd1,
    ST_TRUNC_PAIR = 2'd2,
    ST_BAD_DIST   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CK_NONE,
    CK_LIT,
    CK_SPACE,
    CK_COPY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        data;
    logic [DIST_W-1:0] distance;
    logic [LEN_W-1:0]  len;
    status_t           err;
    logic              last;
    logic              sod;
  } cmd_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SPACE,
    BS_LIT,
    BS_READ,
    BS_COPY,
    BS_ERR
  } back_state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/palmdoc_lz77_decompressor_top.sv -----
// Top level of the PalmDoc LZ77 decompressor.
`timescale 1ns / 1ps
`default_nettype none
// Takes one compressed byte per request and returns decompressed bytes, one per
// request, with a status result that ends the record on a truncated run, a
// truncated pair or a bad distance; bytes after an error are dropped until the
// end of the record. A front end decodes control bytes and can take a byte in
// every cycle while its four-entry command queue has room. The back end sets the
// rate: after it fetches a command it loads each literal or space byte, does a
// history read, then a write and result load, for each copied byte through the
// single history memory, or loads an error result. Results sit in an output
// register, so the front end keeps decoding while a result waits. The history
// memory is not cleared at reset and needs no start-up pass; a start of document
// resets the write pointer, the produced count and the front end's pending
// literal run, pair and drain state.
module palmdoc_lz77_decompressor_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_of_record,
  input  wire logic       start_of_document,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [1:0]      status,
  output logic            end_of_record,
  output logic            last_of_run
);
  import pld_pkg::*;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t q_wdata;
  cmd_t q_rdata;

  pld_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .data_byte         (data_byte),
    .last_of_record    (last_of_record),
    .start_of_document (start_of_document),
    .q_push            (q_push),
    .q_wdata           (q_wdata),
    .q_full            (q_full)
  );

  pld_cmd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  pld_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_rdata       (q_rdata),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .status        (status),
    .end_of_record (end_of_record),
    .last_of_run   (last_of_run)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/pld_front.sv -----
// Front end: accepts compressed bytes, tracks decode state and issues commands.
`timescale 1ns / 1ps
`default_nettype none
module pld_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    data_byte,
  input  wire logic          last_of_record,
  input  wire logic          start_of_document,
  output logic               q_push,
  output pld_pkg::cmd_t      q_wdata,
  input  wire logic          q_full
);
  import pld_pkg::*;

  logic [LEN_W-1:0]   literal_remaining, literal_remaining_next;
  logic               pair_pending, pair_pending_next;
  logic [7:0]         pair_high_byte, pair_high_byte_next;
  logic               draining, draining_next;
  logic [COUNT_W-1:0] produced_count, produced_count_next;
  logic               sod_pending, sod_pending_next;

  logic [LEN_W-1:0]   lrem_eff;
  logic               pp_eff;
  logic               drain_eff;
  logic [COUNT_W-1:0] count_eff;
  logic [15:0]        word;
  logic [DIST_W-1:0]  distance;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   emitted;
  logic [COUNT_W:0]   count_sum;
  logic               accept;
  logic               push;
  cmd_t               cmd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign word     = {pair_high_byte, data_byte};
  assign distance = word[13:3];
  assign len      = {1'b0, word[2:0]} + LEN_BIAS;

  always_comb begin
    lrem_eff  = start_of_document ? '0 : literal_remaining;
    pp_eff    = start_of_document ? 1'b0 : pair_pending;
    drain_eff = start_of_document ? 1'b0 : draining;
    count_eff = start_of_document ? '0 : produced_count;

    literal_remaining_next = lrem_eff;
    pair_pending_next      = pp_eff;
    pair_high_byte_next    = pair_high_byte;
    draining_next          = drain_eff;
    emitted                = '0;
    push                   = 1'b0;

    cmd.kind     = CK_NONE;
    cmd.data     = data_byte;
    cmd.distance = distance;
    cmd.len      = len;
    cmd.err      = ST_OK;
    cmd.last     = last_of_record;
    cmd.sod      = sod_pending || start_of_document;

    if (drain_eff) begin
      if (last_of_record) begin
        draining_next = 1'b0;
      end
    end else if (lrem_eff != '0) begin
      push                   = 1'b1;
      cmd.kind               = CK_LIT;
      emitted                = 4'd1;
      literal_remaining_next = lrem_eff - 4'd1;
      if (last_of_record && (literal_remaining_next != '0)) begin
        cmd.err = ST_TRUNC_LIT;
      end
    end else if (pp_eff) begin
      push              = 1'b1;
      pair_pending_next = 1'b0;
      if ((distance == '0) || (COUNT_W'(distance) > count_eff)) begin
        cmd.err = ST_BAD_DIST;
      end else begin
        cmd.kind = CK_COPY;
        emitted  = len;
      end
    end else if (data_byte inside {[8'd1:RUN_MAX]}) begin
      literal_remaining_next = data_byte[LEN_W-1:0];
      if (last_of_record) begin
        push    = 1'b1;
        cmd.err = ST_TRUNC_LIT;
      end
    end else if (data_byte < PAIR_BASE) begin
      push     = 1'b1;
      cmd.kind = CK_LIT;
      emitted  = 4'd1;
    end else if (data_byte < SPACE_BASE) begin
      pair_pending_next   = 1'b1;
      pair_high_byte_next = data_byte;
      if (last_of_record) begin
        push    = 1'b1;
        cmd.err = ST_TRUNC_PAIR;
      end
    end else begin
      push     = 1'b1;
      cmd.kind = CK_SPACE;
      cmd.data = data_byte ^ HIGH_FLIP;
      emitted  = 4'd2;
    end

    if (cmd.err != ST_OK) begin
      literal_remaining_next = '0;
      pair_pending_next      = 1'b0;
      if (!last_of_record) begin
        draining_next = 1'b1;
      end
    end

    count_sum = {1'b0, count_eff} + (COUNT_W + 1)'(emitted);
    if (count_sum >= {1'b0, COUNT_SAT}) begin
      produced_count_next = COUNT_SAT;
    end else begin
      produced_count_next = count_sum[COUNT_W-1:0];
    end

    if (push) begin
      sod_pending_next = 1'b0;
    end else begin
      sod_pending_next = sod_pending || start_of_document;
    end
  end

  assign q_push  = accept && push;
  assign q_wdata = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      literal_remaining <= '0;
      pair_pending      <= 1'b0;
      pair_high_byte    <= '0;
      draining          <= 1'b0;
      produced_count    <= '0;
      sod_pending       <= 1'b0;
    end else if (accept) begin
      literal_remaining <= literal_remaining_next;
      pair_pending      <= pair_pending_next;
      pair_high_byte    <= pair_high_byte_next;
      draining          <= draining_next;
      produced_count    <= produced_count_next;
      sod_pending       <= sod_pending_next;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pld_cmd_queue.sv -----
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module pld_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire pld_pkg::cmd_t wdata,
  output logic               full,
  input  wire logic          pop,
  output pld_pkg::cmd_t      rdata,
  output logic               empty
);
  import pld_pkg::*;

  cmd_t             entries [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr;
  logic [CQ_AW-1:0] rd_ptr;
  logic [CQ_AW:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (CQ_AW + 1)'(CQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pld_back.sv -----
// Back end: carries out commands against the history and drives the result register.
`timescale 1ns / 1ps
`default_nettype none
module pld_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pld_pkg::cmd_t q_rdata,
  input  wire logic          q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic [1:0]         status,
  output logic               end_of_record,
  output logic               last_of_run
);
  import pld_pkg::*;

  back_state_t        state, state_next;
  cmd_t               cmd;
  logic [LEN_W-1:0]   cnt;
  logic [HIST_AW-1:0] wp;
  logic [7:0]         hist [HIST_DEPTH];
  logic [7:0]         rd_data;
  logic [HIST_AW-1:0] rd_addr;

  logic               can_load;
  logic               load;
  logic [7:0]         ld_byte;
  status_t            ld_status;
  logic               ld_eor;
  logic               ld_lor;
  logic               hist_we;
  logic               hist_re;
  logic               final_emit;
  back_state_t        fin_state;

  assign can_load  = !out_valid || out_ready;
  assign rd_addr   = wp - HIST_AW'(cmd.distance);
  assign fin_state = (cmd.err != ST_OK) ? BS_ERR : BS_IDLE;

  always_comb begin
    state_next = state;
    case (state)
      BS_IDLE: begin
        if (!q_empty) begin
          case (q_rdata.kind)
            CK_NONE:  state_next = BS_ERR;
            CK_LIT:   state_next = BS_LIT;
            CK_SPACE: state_next = BS_SPACE;
            CK_COPY:  state_next = BS_READ;
            default:  state_next = BS_IDLE;
          endcase
        end
      end
      BS_SPACE: begin
        if (can_load) begin
          state_next = BS_LIT;
        end
      end
      BS_LIT: begin
        if (can_load) begin
          state_next = fin_state;
        end
      end
      BS_READ: begin
        state_next = BS_COPY;
      end
      BS_COPY: begin
        if (can_load) begin
          state_next = (cnt == 4'd1) ? fin_state : BS_READ;
        end
      end
      BS_ERR: begin
        if (can_load) begin
          state_next = BS_IDLE;
        end
      end
      default: state_next = BS_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    load       = 1'b0;
    ld_byte    = '0;
    ld_status  = ST_OK;
    final_emit = 1'b0;
    hist_we    = 1'b0;
    hist_re    = 1'b0;
    case (state)
      BS_IDLE: begin
        q_pop = !q_empty;
      end
      BS_SPACE: begin
        load    = can_load;
        hist_we = can_load;
        ld_byte = SPACE_CHAR;
      end
      BS_LIT: begin
        load       = can_load;
        hist_we    = can_load;
        ld_byte    = cmd.data;
        final_emit = 1'b1;
      end
      BS_READ: begin
        hist_re = 1'b1;
      end
      BS_COPY: begin
        load       = can_load;
        hist_we    = can_load;
        ld_byte    = rd_data;
        final_emit = (cnt == 4'd1);
      end
      BS_ERR: begin
        load      = can_load;
        ld_status = cmd.err;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
    if (state == BS_ERR) begin
      ld_eor = 1'b1;
      ld_lor = 1'b1;
    end else begin
      ld_lor = final_emit && (cmd.err == ST_OK);
      ld_eor = ld_lor && cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist[wp] <= ld_byte;
    end
    if (hist_re) begin
      rd_data <= hist[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_rdata;
    end
    if (load) begin
      out_byte      <= ld_byte;
      status        <= ld_status;
      end_of_record <= ld_eor;
      last_of_run   <= ld_lor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BS_IDLE;
      cnt       <= '0;
      wp        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        cnt <= q_rdata.len;
        if (q_rdata.sod) begin
          wp <= '0;
        end
      end else if (hist_we) begin
        wp <= wp + 1'b1;
        if (state == BS_COPY) begin
          cnt <= cnt - 4'd1;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pld_checker.sv -----
// Port-level checks for the PalmDoc LZ77 decompressor and their bind.
`timescale 1ns / 1ps
`default_nettype none
module pld_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic [1:0] status,
  input wire logic       end_of_record,
  input wire logic       last_of_run
);
  import pld_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status))
    else $error("stalled result changed");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> end_of_record && last_of_run && (out_byte == 8'd0))
    else $error("error result malformed");

  a_eor_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_record |-> last_of_run)
    else $error("record end without end of run");

endmodule

bind palmdoc_lz77_decompressor_top pld_checker u_pld_checker (.*);
`default_nettype wire
